### design/tmc_pkg.sv
// ----------------------------------------------------------------------------
// Thresholded mask centroid package
// Shared constants, register indexes and the configuration register type.
// ----------------------------------------------------------------------------
package tmc_pkg;

    // Default sizing of the image and of the fixed-point result
    localparam int MAX_WIDTH_DEFAULT     = 2048;
    localparam int MAX_HEIGHT_DEFAULT    = 2048;
    localparam int FRACTION_BITS_DEFAULT = 4;

    // Field widths fixed by the interface
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int THR_W      = 8;
    localparam int MINC_W     = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int CENTER_W   = 15;
    localparam int CENTER_MAX = 32767;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    // Depth of the queue between the pixel front end and the divider back end
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT    = 3'd5;

    // Reset values of the registers
    localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 12'd2048;
    localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 12'd2048;
    localparam logic [CFG_W-1:0]  RST_COLUMN_STEP  = 12'd20;
    localparam logic [CFG_W-1:0]  RST_ROW_STEP     = 12'd20;
    localparam logic [THR_W-1:0]  RST_THRESHOLD    = 8'd0;
    localparam logic [MINC_W-1:0] RST_MIN_COUNT    = 23'd50;

    typedef struct packed {
        logic [CFG_W-1:0]  frame_width;
        logic [CFG_W-1:0]  frame_height;
        logic [CFG_W-1:0]  column_step;
        logic [CFG_W-1:0]  row_step;
        logic [THR_W-1:0]  threshold;
        logic [MINC_W-1:0] min_count;
    } cfg_regs_t;

endpackage

### design/tmc_fifo.sv
// ----------------------------------------------------------------------------
// Frame result queue
// Small register queue that holds finished frame sums until the back end
// is free to divide them.
// ----------------------------------------------------------------------------
module tmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tmc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/tmc_front.sv
// ----------------------------------------------------------------------------
// Centroid front end
// Thresholds each pixel, tracks the raster position and accumulates the
// lit counts and index sums; hands the sums to the queue at frame end.
// ----------------------------------------------------------------------------
module tmc_front #(
    parameter int MAX_WIDTH  = tmc_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = tmc_pkg::MAX_HEIGHT_DEFAULT,
    parameter int ENTRY_W    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tmc_pkg::cfg_regs_t          cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tmc_pkg::PIX_W-1:0]   s_tdata,
    input  logic                        queue_full,
    output logic                        push,
    output logic [ENTRY_W-1:0]          push_data
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int IDY_W = $clog2(MAX_HEIGHT);
    localparam int DW_W  = $clog2(MAX_WIDTH + 1);
    localparam int DH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int WX_W  = IDX_W + CNT_W;
    localparam int WY_W  = IDY_W + CNT_W;
    localparam int RAW_W = tmc_pkg::CFG_W + 1;
    localparam int CMP_W = (CNT_W > tmc_pkg::MINC_W) ? CNT_W : tmc_pkg::MINC_W;

    logic [IDX_W-1:0] col_idx_reg;
    logic [IDX_W-1:0] col_phase_reg;
    logic [IDY_W-1:0] row_idx_reg;
    logic [IDY_W-1:0] row_phase_reg;
    logic [CNT_W-1:0] cnt_x_reg;
    logic [WX_W-1:0]  wx_reg;
    logic [CNT_W-1:0] cnt_y_reg;
    logic [WY_W-1:0]  wy_reg;

    logic [RAW_W-1:0] w_raw, h_raw, cs_raw, rs_raw;
    logic [DW_W-1:0]  w_eff, cs_eff, col_inc, col_ph_inc;
    logic [DH_W-1:0]  h_eff, rs_eff, row_inc, row_ph_inc;
    logic             accept, lit, add_x, add_y;
    logic             col_last, row_last, frame_end, present;
    logic [CNT_W-1:0] cnt_x_next, cnt_y_next;
    logic [WX_W-1:0]  wx_next;
    logic [WY_W-1:0]  wy_next;

    // A size or step of zero acts as one; anything beyond the maximum is clamped.
    assign w_raw  = {1'b0, cfg.frame_width};
    assign h_raw  = {1'b0, cfg.frame_height};
    assign cs_raw = {1'b0, cfg.column_step};
    assign rs_raw = {1'b0, cfg.row_step};

    assign w_eff  = (w_raw == '0) ? DW_W'(1) :
                    (w_raw > RAW_W'(MAX_WIDTH)) ? DW_W'(MAX_WIDTH) : DW_W'(w_raw);
    assign cs_eff = (cs_raw == '0) ? DW_W'(1) :
                    (cs_raw > RAW_W'(MAX_WIDTH)) ? DW_W'(MAX_WIDTH) : DW_W'(cs_raw);
    assign h_eff  = (h_raw == '0) ? DH_W'(1) :
                    (h_raw > RAW_W'(MAX_HEIGHT)) ? DH_W'(MAX_HEIGHT) : DH_W'(h_raw);
    assign rs_eff = (rs_raw == '0) ? DH_W'(1) :
                    (rs_raw > RAW_W'(MAX_HEIGHT)) ? DH_W'(MAX_HEIGHT) : DH_W'(rs_raw);

    // Room for a possible frame result is kept before any pixel is taken.
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign lit      = (s_tdata >= cfg.threshold);
    assign add_x    = lit && (col_phase_reg == '0);
    assign add_y    = lit && (row_phase_reg == '0);

    assign cnt_x_next = cnt_x_reg + CNT_W'(add_x);
    assign wx_next    = wx_reg + (add_x ? WX_W'(col_idx_reg) : '0);
    assign cnt_y_next = cnt_y_reg + CNT_W'(add_y);
    assign wy_next    = wy_reg + (add_y ? WY_W'(row_idx_reg) : '0);

    assign col_inc    = DW_W'(col_idx_reg) + DW_W'(1);
    assign col_ph_inc = DW_W'(col_phase_reg) + DW_W'(1);
    assign row_inc    = DH_W'(row_idx_reg) + DH_W'(1);
    assign row_ph_inc = DH_W'(row_phase_reg) + DH_W'(1);

    assign col_last  = !(col_inc < w_eff);
    assign row_last  = !(row_inc < h_eff);
    assign frame_end = col_last && row_last;

    assign present   = (CMP_W'(cnt_y_next) > CMP_W'(cfg.min_count));
    assign push      = accept && frame_end;
    assign push_data = ENTRY_W'({present, cnt_y_next, wy_next, cnt_x_next, wx_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg   <= '0;
            col_phase_reg <= '0;
            row_idx_reg   <= '0;
            row_phase_reg <= '0;
            cnt_x_reg     <= '0;
            wx_reg        <= '0;
            cnt_y_reg     <= '0;
            wy_reg        <= '0;
        end
        else if (accept)
        begin
            if (!col_last)
            begin
                col_idx_reg   <= IDX_W'(col_inc);
                col_phase_reg <= (col_ph_inc >= cs_eff) ? '0 : IDX_W'(col_ph_inc);
                cnt_x_reg     <= cnt_x_next;
                wx_reg        <= wx_next;
                cnt_y_reg     <= cnt_y_next;
                wy_reg        <= wy_next;
            end
            else if (!row_last)
            begin
                col_idx_reg   <= '0;
                col_phase_reg <= '0;
                row_idx_reg   <= IDY_W'(row_inc);
                row_phase_reg <= (row_ph_inc >= rs_eff) ? '0 : IDY_W'(row_ph_inc);
                cnt_x_reg     <= cnt_x_next;
                wx_reg        <= wx_next;
                cnt_y_reg     <= cnt_y_next;
                wy_reg        <= wy_next;
            end
            else
            begin
                // Frame complete: the sums have gone to the queue.
                col_idx_reg   <= '0;
                col_phase_reg <= '0;
                row_idx_reg   <= '0;
                row_phase_reg <= '0;
                cnt_x_reg     <= '0;
                wx_reg        <= '0;
                cnt_y_reg     <= '0;
                wy_reg        <= '0;
            end
        end
    end

endmodule

### design/tmc_div.sv
// ----------------------------------------------------------------------------
// Centroid divider
// Restoring divider, one quotient bit per cycle, giving the saturated
// fixed-point mean index of one strip.
// ----------------------------------------------------------------------------
module tmc_div #(
    parameter int IDX_W         = 11,
    parameter int CNT_W         = 23,
    parameter int FRACTION_BITS = tmc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [IDX_W+CNT_W-1:0]         num,
    input  logic [CNT_W-1:0]               den,
    output logic                           busy,
    output logic [tmc_pkg::CENTER_W-1:0]   center
);

    // The mean of indices never reaches 2^IDX_W, so the quotient has Q_W bits
    // and the numerator bits above them are already below the divisor.
    localparam int Q_W    = IDX_W + FRACTION_BITS;
    localparam int NUM_W  = IDX_W + CNT_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(Q_W);
    localparam int QX_W   = (Q_W > tmc_pkg::CENTER_W) ? Q_W : tmc_pkg::CENTER_W;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [Q_W-1:0]    sh_reg;
    logic [CNT_W-1:0]  den_reg;
    logic              zero_reg;

    logic [NUM_W-1:0]  num_full;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [QX_W-1:0]   quot;

    assign num_full = NUM_W'(num) << FRACTION_BITS;
    assign trial    = {rem_reg, sh_reg[Q_W-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign quot     = QX_W'(sh_reg);
    assign busy     = busy_reg;
    assign center   = zero_reg ? '0 :
                      (quot > QX_W'(tmc_pkg::CENTER_MAX)) ?
                      tmc_pkg::CENTER_W'(tmc_pkg::CENTER_MAX) : tmc_pkg::CENTER_W'(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            sh_reg   <= '0;
            den_reg  <= '0;
            zero_reg <= 1'b1;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            rem_reg  <= num_full[NUM_W-1:Q_W];
            sh_reg   <= num_full[Q_W-1:0];
            den_reg  <= den;
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? CNT_W'(trial - {1'b0, den_reg}) : CNT_W'(trial);
            sh_reg   <= {sh_reg[Q_W-2:0], fits};
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(Q_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

### design/tmc_back.sv
// ----------------------------------------------------------------------------
// Centroid back end
// Takes frame sums from the queue, runs both divisions and holds the
// result in the output register until it is transferred.
// ----------------------------------------------------------------------------
module tmc_back #(
    parameter int MAX_WIDTH     = tmc_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT    = tmc_pkg::MAX_HEIGHT_DEFAULT,
    parameter int FRACTION_BITS = tmc_pkg::FRACTION_BITS_DEFAULT,
    parameter int ENTRY_W       = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           queue_empty,
    input  logic [ENTRY_W-1:0]             pop_data,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tmc_pkg::CENTER_W-1:0]   x_center,
    output logic [tmc_pkg::CENTER_W-1:0]   y_center,
    output logic                           present,
    output logic                           empty_x,
    output logic                           empty_y
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int IDY_W = $clog2(MAX_HEIGHT);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int WX_W  = IDX_W + CNT_W;
    localparam int WY_W  = IDY_W + CNT_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                         state_reg;
    logic                           m_tvalid_reg;
    logic [tmc_pkg::CENTER_W-1:0]   x_center_reg;
    logic [tmc_pkg::CENTER_W-1:0]   y_center_reg;
    logic                           present_reg;
    logic                           empty_x_reg;
    logic                           empty_y_reg;
    logic                           hold_present_reg;
    logic                           hold_empty_x_reg;
    logic                           hold_empty_y_reg;

    logic [WX_W-1:0]                e_wx;
    logic [CNT_W-1:0]               e_cnt_x;
    logic [WY_W-1:0]                e_wy;
    logic [CNT_W-1:0]               e_cnt_y;
    logic                           e_present;
    logic                           busy_x, busy_y;
    logic [tmc_pkg::CENTER_W-1:0]   cx, cy;
    logic                           out_free;
    logic                           load_out;

    assign {e_present, e_cnt_y, e_wy, e_cnt_x, e_wx} = pop_data[2*CNT_W+WX_W+WY_W:0];

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign out_free = !m_tvalid_reg || m_tready;
    // Both quotients ready and the output register free to refill.
    assign load_out = (state_reg == ST_RUN) && !busy_x && !busy_y && out_free;

    tmc_div #(
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pop),
        .num    (e_wx),
        .den    (e_cnt_x),
        .busy   (busy_x),
        .center (cx)
    );

    tmc_div #(
        .IDX_W         (IDY_W),
        .CNT_W         (CNT_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pop),
        .num    (e_wy),
        .den    (e_cnt_y),
        .busy   (busy_y),
        .center (cy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            x_center_reg     <= '0;
            y_center_reg     <= '0;
            present_reg      <= 1'b0;
            empty_x_reg      <= 1'b0;
            empty_y_reg      <= 1'b0;
            hold_present_reg <= 1'b0;
            hold_empty_x_reg <= 1'b0;
            hold_empty_y_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        hold_present_reg <= e_present;
                        hold_empty_x_reg <= (e_cnt_x == '0);
                        hold_empty_y_reg <= (e_cnt_y == '0);
                        state_reg        <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (load_out)
                    begin
                        x_center_reg <= cx;
                        y_center_reg <= cy;
                        present_reg  <= hold_present_reg;
                        empty_x_reg  <= hold_empty_x_reg;
                        empty_y_reg  <= hold_empty_y_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign x_center = x_center_reg;
    assign y_center = y_center_reg;
    assign present  = present_reg;
    assign empty_x  = empty_x_reg;
    assign empty_y  = empty_y_reg;

endmodule

### design/threshold_mask_centroid.sv
// ----------------------------------------------------------------------------
// Thresholded mask centroid
// Computes the subsampled centroid of the lit pixels of each image frame.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ group in raster order, one per transfer; frame size
// comes from the registers, so no frame marker is needed. After the last
// pixel of a frame one result leaves on the m_ group: x and y centres in
// unsigned fixed point, plus the present and empty flags.
// The front end takes one pixel per cycle while the queue is not full. Each
// frame's sums go through a two-entry queue to a back end whose two restoring
// dividers produce one quotient bit per cycle. After the transfer of the last
// pixel of a frame its sums are pushed into the queue, popped into the dividers
// and the result is loaded into the output register, where m_tvalid rises. The
// back end takes the next frame only once the current result has been loaded
// into the output register, so short frames are paced by the dividers.
// When the receiver stalls, the result waits in the output register, the
// queue fills and s_tready falls only once the queue is full.
// Reset clears the frame position and sums and loads the register defaults.
// Configuration writes on the cfg_ group are always accepted and take effect
// on the next pixel.
// ----------------------------------------------------------------------------
module threshold_mask_centroid #(
    parameter int MAX_WIDTH     = tmc_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT    = tmc_pkg::MAX_HEIGHT_DEFAULT,
    parameter int FRACTION_BITS = tmc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tmc_pkg::PIX_W-1:0]           s_tdata,    // [7:0] pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tmc_pkg::OUT_DATA_W-1:0]      m_tdata,    // [14:0] x_center, [29:15] y_center
    output logic [tmc_pkg::OUT_USER_W-1:0]      m_tuser,    // [0] present, [1] empty_x, [2] empty_y
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W   = $clog2(MAX_WIDTH);
    localparam int IDY_W   = $clog2(MAX_HEIGHT);
    localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ENTRY_W = 2 * CNT_W + IDX_W + CNT_W + IDY_W + CNT_W + 1;

    tmc_pkg::cfg_regs_t              cfg_reg;
    logic                            q_push, q_full, q_pop, q_empty;
    logic [ENTRY_W-1:0]              q_push_data, q_pop_data;
    logic [tmc_pkg::CENTER_W-1:0]    x_center, y_center;
    logic                            present, empty_x, empty_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= tmc_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= tmc_pkg::RST_FRAME_HEIGHT;
            cfg_reg.column_step  <= tmc_pkg::RST_COLUMN_STEP;
            cfg_reg.row_step     <= tmc_pkg::RST_ROW_STEP;
            cfg_reg.threshold    <= tmc_pkg::RST_THRESHOLD;
            cfg_reg.min_count    <= tmc_pkg::RST_MIN_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tmc_pkg::REG_FRAME_WIDTH:
                begin
                    cfg_reg.frame_width <= cfg_data[tmc_pkg::CFG_W-1:0];
                end
                tmc_pkg::REG_FRAME_HEIGHT:
                begin
                    cfg_reg.frame_height <= cfg_data[tmc_pkg::CFG_W-1:0];
                end
                tmc_pkg::REG_COLUMN_STEP:
                begin
                    cfg_reg.column_step <= cfg_data[tmc_pkg::CFG_W-1:0];
                end
                tmc_pkg::REG_ROW_STEP:
                begin
                    cfg_reg.row_step <= cfg_data[tmc_pkg::CFG_W-1:0];
                end
                tmc_pkg::REG_THRESHOLD:
                begin
                    cfg_reg.threshold <= cfg_data[tmc_pkg::THR_W-1:0];
                end
                tmc_pkg::REG_MIN_COUNT:
                begin
                    cfg_reg.min_count <= cfg_data[tmc_pkg::MINC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    tmc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    tmc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (tmc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    tmc_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .pop_data    (q_pop_data),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .x_center    (x_center),
        .y_center    (y_center),
        .present     (present),
        .empty_x     (empty_x),
        .empty_y     (empty_y)
    );

    assign m_tdata = tmc_pkg::OUT_DATA_W'({y_center, x_center});
    assign m_tuser = {empty_y, empty_x, present};

endmodule

### test/threshold_mask_centroid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thresholded mask centroid testbench
// Streams raster pixels into the block under many register settings. The
// tracker class follows the frame position and the strip sums of every
// accepted pixel and compares each frame result on m_tdata/m_tuser field by
// field. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module threshold_mask_centroid_tb;
    import tmc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
    localparam int                   SETTLE_CYCLES = 40;
    localparam int                   RANDOM_PIXELS = 1560;
    localparam logic [CFG_W-1:0]     OVERSIZE      = 12'hFFF;

    typedef struct packed {
        logic [CENTER_W-1:0] x_center;
        logic [CENTER_W-1:0] y_center;
        logic                present;
        logic                empty_x;
        logic                empty_y;
    } centroid_t;

    class centroid_tracker;
        cfg_regs_t       regs;
        int unsigned     col_idx, row_idx, col_phase, row_phase;
        longint unsigned count_x, sum_x, count_y, sum_y;
        centroid_t       frames_due[$];
        int unsigned     mismatches, frames_seen, pixels_seen;

        function new();
            regs.frame_width  = RST_FRAME_WIDTH;
            regs.frame_height = RST_FRAME_HEIGHT;
            regs.column_step  = RST_COLUMN_STEP;
            regs.row_step     = RST_ROW_STEP;
            regs.threshold    = RST_THRESHOLD;
            regs.min_count    = RST_MIN_COUNT;
            mismatches  = 0;
            frames_seen = 0;
            pixels_seen = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            col_idx   = 0;
            row_idx   = 0;
            col_phase = 0;
            row_phase = 0;
            count_x   = 0;
            sum_x     = 0;
            count_y   = 0;
            sum_y     = 0;
        endfunction

        // A size or step of zero behaves as one; anything past the maximum is clamped.
        function int unsigned span(logic [CFG_W-1:0] v, int unsigned hi);
            if (v == 0)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return span(regs.frame_width, MAX_WIDTH_DEFAULT)
                 * span(regs.frame_height, MAX_HEIGHT_DEFAULT);
        endfunction

        function logic [CENTER_W-1:0] fixed_centre(longint unsigned weighted,
                                                   longint unsigned lit_count);
            longint unsigned q;
            if (lit_count == 0)
                return '0;
            q = (weighted << FRACTION_BITS_DEFAULT) / lit_count;
            if (q > CENTER_MAX)
                q = CENTER_MAX;
            return CENTER_W'(q);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  regs.frame_width  = data[CFG_W-1:0];
                REG_FRAME_HEIGHT: regs.frame_height = data[CFG_W-1:0];
                REG_COLUMN_STEP:  regs.column_step  = data[CFG_W-1:0];
                REG_ROW_STEP:     regs.row_step     = data[CFG_W-1:0];
                REG_THRESHOLD:    regs.threshold    = data[THR_W-1:0];
                REG_MIN_COUNT:    regs.min_count    = data[MINC_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int unsigned w, h, cs, rs;
            bit          lit;
            centroid_t   due;
            w   = span(regs.frame_width, MAX_WIDTH_DEFAULT);
            h   = span(regs.frame_height, MAX_HEIGHT_DEFAULT);
            cs  = span(regs.column_step, MAX_WIDTH_DEFAULT);
            rs  = span(regs.row_step, MAX_HEIGHT_DEFAULT);
            lit = (pix >= regs.threshold);
            pixels_seen++;
            if (lit && col_phase == 0) begin
                count_x++;
                sum_x += col_idx;
            end
            if (lit && row_phase == 0) begin
                count_y++;
                sum_y += row_idx;
            end
            // Registers may shrink mid-frame, so the row and frame ends test with a
            // comparison rather than equality.
            if (col_idx + 1 < w) begin
                col_idx++;
                col_phase = (col_phase + 1 >= cs) ? 0 : col_phase + 1;
            end
            else if (row_idx + 1 < h) begin
                col_idx   = 0;
                col_phase = 0;
                row_idx++;
                row_phase = (row_phase + 1 >= rs) ? 0 : row_phase + 1;
            end
            else begin
                due.x_center = fixed_centre(sum_x, count_x);
                due.y_center = fixed_centre(sum_y, count_y);
                due.present  = (count_y > regs.min_count);
                due.empty_x  = (count_x == 0);
                due.empty_y  = (count_y == 0);
                frames_due.push_back(due);
                clear_frame();
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] tdata, logic [OUT_USER_W-1:0] tuser);
            centroid_t want, got;
            got.x_center = tdata[CENTER_W-1:0];
            got.y_center = tdata[2*CENTER_W-1:CENTER_W];
            got.present  = tuser[0];
            got.empty_x  = tuser[1];
            got.empty_y  = tuser[2];
            if (frames_due.size() == 0) begin
                $error("result with no frame pending: tdata=%h tuser=%b", tdata, tuser);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            frames_seen++;
            if (got.x_center !== want.x_center) begin
                $error("x_center: expected %0d, got %0d", want.x_center, got.x_center);
                mismatches++;
            end
            if (got.y_center !== want.y_center) begin
                $error("y_center: expected %0d, got %0d", want.y_center, got.y_center);
                mismatches++;
            end
            if (got.present !== want.present) begin
                $error("present: expected %b, got %b", want.present, got.present);
                mismatches++;
            end
            if (got.empty_x !== want.empty_x) begin
                $error("empty_x: expected %b, got %b", want.empty_x, got.empty_x);
                mismatches++;
            end
            if (got.empty_y !== want.empty_y) begin
                $error("empty_y: expected %b, got %b", want.empty_y, got.empty_y);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;      // [7:0] pixel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;             // [14:0] x_center, [29:15] y_center
    logic [OUT_USER_W-1:0] m_tuser;             // [0] present, [1] empty_x, [2] empty_y
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    centroid_tracker tracker;
    bit              steady      = 1'b0;
    int              hold_cycles = 0;

    threshold_mask_centroid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Mostly short gaps with the odd long one.
    function automatic int idle_length();
        return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
    endfunction

    function automatic int unsigned pick_size(int unsigned usual, int unsigned rare);
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(rare, usual + 1);
            default: return $urandom_range(usual, 1);
        endcase
    endfunction

    function automatic int unsigned pick_step();
        case ($urandom_range(9))
            0:       return 0;
            1:       return OVERSIZE;
            2:       return $urandom_range(2047, 5);
            default: return $urandom_range(4, 1);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(int unsigned style, logic [THR_W-1:0] thr);
        int v;
        case (style)
            0: return PIX_W'($urandom);
            1: return ($urandom_range(7) == 0) ? 8'hFF : PIX_W'($urandom_range(31));
            2:
            begin
                v = int'(thr) + int'($urandom_range(2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                return PIX_W'(v);
            end
            default: return 8'hFF;
        endcase
    endfunction

    // Leaves cfg_valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_register(idx, data);
    endtask

    // Sometimes fills the unused upper bits of the write data with noise.
    task automatic write_field(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                               input int unsigned bits);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if (bits < CFG_DATA_W && $urandom_range(3) == 0)
            data = data | (CFG_DATA_W'($urandom) << bits);
        write_reg(idx, data);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = (!steady && $urandom_range(3) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge clk); while (!s_tready);
        tracker.note_pixel(pix);
    endtask

    // A frame may be left part-way through, so the back end is given time to finish
    // after the last result before the registers change.
    task automatic drain();
        while (tracker.frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end
            else if (!steady && $urandom_range(4) == 0) begin
                m_tready <= 1'b0;
                gap = idle_length() - 1;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser);
    end

    initial
    begin
        logic [PIX_W-1:0] run[$];
        int unsigned      random_pixels, settings, frames, n, style;
        tracker       = new();
        random_pixels = 0;
        settings      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of steps, threshold and min_count with a small frame.
        write_reg(REG_FRAME_WIDTH, 23'd3);
        write_reg(REG_FRAME_HEIGHT, 23'd2);
        cfg_valid <= 1'b0;
        run = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127};
        foreach (run[i])
            send_pixel(run[i]);
        s_tvalid <= 1'b0;
        drain();
        settings++;

        // Zero sizes and steps act as one: every pixel is a frame of its own.
        write_reg(REG_FRAME_WIDTH, 23'd0);
        write_reg(REG_FRAME_HEIGHT, 23'd0);
        write_reg(REG_COLUMN_STEP, 23'd0);
        write_reg(REG_ROW_STEP, 23'd0);
        write_reg(REG_THRESHOLD, 23'd255);
        write_reg(REG_MIN_COUNT, 23'd0);
        cfg_valid <= 1'b0;
        run = '{8'd255, 8'd254, 8'd0};
        foreach (run[i])
            send_pixel(run[i]);
        s_tvalid <= 1'b0;
        drain();
        settings++;

        // One full frame, then the width shrinks below the current column.
        write_reg(REG_FRAME_WIDTH, 23'd3);
        write_reg(REG_FRAME_HEIGHT, 23'd2);
        write_reg(REG_COLUMN_STEP, 23'd1);
        write_reg(REG_ROW_STEP, 23'd2);
        write_reg(REG_THRESHOLD, 23'd128);
        write_reg(REG_MIN_COUNT, 23'd2);
        cfg_valid <= 1'b0;
        run = '{8'd128, 8'd127, 8'd200, 8'd255, 8'd0, 8'd130, 8'd255, 8'd255, 8'd255,
                8'd129, 8'd140};
        foreach (run[i])
            send_pixel(run[i]);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_FRAME_WIDTH, 23'd2);
        cfg_valid <= 1'b0;
        send_pixel(8'd131);
        s_tvalid <= 1'b0;
        drain();
        settings++;

        // The height shrinks below the current row.
        write_reg(REG_FRAME_WIDTH, 23'd1);
        write_reg(REG_FRAME_HEIGHT, 23'd4);
        write_reg(REG_ROW_STEP, 23'd1);
        write_reg(REG_MIN_COUNT, 23'h7FFFFF);
        cfg_valid <= 1'b0;
        run = '{8'd200, 8'd100, 8'd250};
        foreach (run[i])
            send_pixel(run[i]);
        s_tvalid <= 1'b0;
        drain();
        write_reg(REG_FRAME_HEIGHT, 23'd2);
        cfg_valid <= 1'b0;
        send_pixel(8'd255);
        s_tvalid <= 1'b0;
        drain();
        settings++;

        // Output held off while single-pixel frames keep coming, so the queue
        // fills and the input stalls.
        write_reg(REG_FRAME_HEIGHT, 23'd1);
        write_reg(REG_THRESHOLD, 23'd60);
        write_reg(REG_MIN_COUNT, 23'd0);
        cfg_valid <= 1'b0;
        steady      = 1'b1;
        hold_cycles = 300;
        repeat (40)
            send_pixel(PIX_W'($urandom));
        s_tvalid <= 1'b0;
        drain();
        steady = 1'b0;
        settings++;

        // Oversized width, then oversized height, with the step of the other axis oversized; each frame
        // is ended early by shrinking the register part-way through.
        for (int k = 0; k < 2; k++) begin
            write_reg(REG_FRAME_WIDTH, (k == 0) ? CFG_DATA_W'(OVERSIZE) : 23'd1);
            write_reg(REG_FRAME_HEIGHT, (k == 0) ? 23'd1 : CFG_DATA_W'(OVERSIZE));
            write_reg(REG_COLUMN_STEP, (k == 0) ? 23'd1 : CFG_DATA_W'(OVERSIZE));
            write_reg(REG_ROW_STEP, (k == 0) ? CFG_DATA_W'(OVERSIZE) : 23'd1);
            write_reg(REG_THRESHOLD, 23'd100);
            cfg_valid <= 1'b0;
            for (int i = 0; i < 12; i++)
                send_pixel(PIX_W'($urandom));
            s_tvalid <= 1'b0;
            drain();
            write_reg((k == 0) ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT, 23'd13);
            cfg_valid <= 1'b0;
            send_pixel(8'hFF);
            s_tvalid <= 1'b0;
            drain();
            settings++;
        end

        while (random_pixels < RANDOM_PIXELS) begin
            steady = ($urandom_range(7) == 0);
            if ($urandom_range(2) != 0)
                write_field(REG_FRAME_WIDTH, pick_size(8, 16), CFG_W);
            if ($urandom_range(2) != 0)
                write_field(REG_FRAME_HEIGHT, pick_size(6, 10), CFG_W);
            if ($urandom_range(1) != 0)
                write_field(REG_COLUMN_STEP, pick_step(), CFG_W);
            if ($urandom_range(1) != 0)
                write_field(REG_ROW_STEP, pick_step(), CFG_W);
            if ($urandom_range(1) != 0) begin
                case ($urandom_range(4))
                    0:       write_field(REG_THRESHOLD, 0, THR_W);
                    1:       write_field(REG_THRESHOLD, 255, THR_W);
                    default: write_field(REG_THRESHOLD, $urandom_range(255), THR_W);
                endcase
            end
            if ($urandom_range(1) != 0) begin
                case ($urandom_range(4))
                    0:       write_field(REG_MIN_COUNT, 0, MINC_W);
                    1:       write_field(REG_MIN_COUNT, 23'h7FFFFF, MINC_W);
                    2:       write_field(REG_MIN_COUNT, $urandom, MINC_W);
                    default: write_field(REG_MIN_COUNT, $urandom_range(8), MINC_W);
                endcase
            end
            if ($urandom_range(9) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            if ($urandom_range(11) == 0)
                hold_cycles = $urandom_range(200, 60);
            frames = $urandom_range(4, 1);
            n      = frames * tracker.frame_pixels();
            // Sometimes stop part-way through a frame; the next settings then apply mid-frame.
            if ($urandom_range(3) == 0)
                n += $urandom_range(tracker.frame_pixels());
            style = $urandom_range(3);
            for (int unsigned i = 0; i < n; i++) begin
                send_pixel(pick_pixel(style, tracker.regs.threshold));
                random_pixels++;
            end
            s_tvalid <= 1'b0;
            drain();
            settings++;
        end

        $display("%0d frame results checked from %0d pixels over %0d register settings,",
                 tracker.frames_seen, tracker.pixels_seen, settings);
        $display("with clamped sizes and steps, mid-frame register changes and output stalls.");
        if (tracker.mismatches == 0)
            $display("threshold_mask_centroid_tb passed");
        else
            $display("threshold_mask_centroid_tb failed");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("threshold_mask_centroid_tb failed");
        $finish;
    end

endmodule

### files.f
design/tmc_pkg.sv
design/tmc_fifo.sv
design/tmc_front.sv
design/tmc_div.sv
design/tmc_back.sv
design/threshold_mask_centroid.sv
test/threshold_mask_centroid_tb.sv
